// File: src/psit_pkg.sv
// Package for the point-in-support-triangles unit.
// Holds widths, request codes, state and step encodings and the controller/datapath
// command and status structs; no dependencies.
package psit_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W        = CNT_W + 1;

    localparam int CRD_W  = 32;
    localparam int VTX_W  = 3 * CRD_W;
    localparam int DIF_W  = CRD_W + 1;
    localparam int LIMB_W = 23;
    localparam int LIMBS  = 3;
    localparam int OPD_W  = LIMB_W * LIMBS;
    localparam int LSEL_W = $clog2(LIMBS);
    localparam int WIDE_W = 140;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_DIFF,
        ST_MSTART,
        ST_MWAIT,
        ST_MWB,
        ST_SUM,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        MS_AA0, MS_AA1, MS_AA2,
        MS_BB0, MS_BB1, MS_BB2,
        MS_AB0, MS_AB1, MS_AB2,
        MS_PA0, MS_PA1, MS_PA2,
        MS_PB0, MS_PB1, MS_PB2,
        MS_DEN0, MS_DEN1,
        MS_SN0, MS_SN1,
        MS_TN0, MS_TN1
    } step_t;

    typedef struct packed {
        logic             clear;
        logic             add;
        logic             cap_q;
        logic [IDX_W-1:0] rd_addr;
        logic             cap_a;
        logic             cap_b;
        logic             cap_c;
        logic             diff;
        logic             mul_start;
        logic             mul_wb;
        step_t            step;
        logic             sum;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             ovf;
        logic             mul_done;
        logic             hit;
    } st_t;

endpackage

// File: src/psit_mul.sv
// Sequential signed multiplier: one LIMB_W x LIMB_W partial product per cycle.
// Depends on psit_pkg.
module psit_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [psit_pkg::OPD_W-1:0] opa,
    input  logic signed [psit_pkg::OPD_W-1:0] opb,
    output logic                              done,
    output logic signed [psit_pkg::WIDE_W-1:0] prod
);
    import psit_pkg::*;

    logic [OPD_W-1:0]      mag_a_reg, mag_b_reg;
    logic                  neg_reg;
    logic [WIDE_W-1:0]     acc_reg;
    logic [LSEL_W-1:0]     ia_reg, ib_reg;
    logic                  busy_reg, fin_reg, done_reg;
    logic signed [WIDE_W-1:0] prod_reg;
    logic [2*LIMB_W-1:0]   pp;
    logic [LSEL_W:0]       pos;
    logic [WIDE_W-1:0]     pp_sh;

    always_comb
    begin
        pp    = mag_a_reg[ia_reg*LIMB_W +: LIMB_W] * mag_b_reg[ib_reg*LIMB_W +: LIMB_W];
        pos   = {1'b0, ia_reg} + {1'b0, ib_reg};
        pp_sh = WIDE_W'(pp) << (LIMB_W * pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            ia_reg   <= '0;
            ib_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ia_reg   <= '0;
                ib_reg   <= '0;
            end
            else if (busy_reg)
            begin
                if (ib_reg == LSEL_W'(LIMBS - 1))
                begin
                    ib_reg <= '0;
                    if (ia_reg == LSEL_W'(LIMBS - 1))
                    begin
                        busy_reg <= 1'b0;
                        fin_reg  <= 1'b1;
                    end
                    else
                    begin
                        ia_reg <= ia_reg + 1'b1;
                    end
                end
                else
                begin
                    ib_reg <= ib_reg + 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_a_reg <= opa[OPD_W-1] ? OPD_W'(-opa) : OPD_W'(opa);
            mag_b_reg <= opb[OPD_W-1] ? OPD_W'(-opb) : OPD_W'(opb);
            neg_reg   <= opa[OPD_W-1] ^ opb[OPD_W-1];
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
        if (fin_reg)
        begin
            prod_reg <= neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: src/psit_datapath.sv
// Datapath: vertex store, query point, edge vectors, dot products and the containment test.
// Depends on psit_pkg and psit_mul.
module psit_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [psit_pkg::VTX_W-1:0]  in_data,
    input  psit_pkg::cmd_t              cmd,
    output psit_pkg::st_t               st
);
    import psit_pkg::*;

    logic [VTX_W-1:0] mem [MAX_VERTICES];
    logic [VTX_W-1:0] rd_reg, va_reg, vb_reg, vc_reg, q_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;

    logic signed [DIF_W-1:0]  a_reg [3];
    logic signed [DIF_W-1:0]  b_reg [3];
    logic signed [DIF_W-1:0]  p_reg [3];
    logic signed [OPD_W-1:0]  aa_reg, bb_reg, ab_reg, pa_reg, pb_reg;
    logic signed [WIDE_W-1:0] den_reg, sn_reg, tn_reg, sum_reg;
    logic signed [WIDE_W-1:0] slack;

    logic signed [OPD_W-1:0]  opa, opb;
    logic signed [WIDE_W-1:0] prod;
    logic signed [OPD_W-1:0]  prod_n;
    logic                     mul_done;

    function automatic logic signed [OPD_W-1:0] sx(input logic signed [DIF_W-1:0] v);
        sx = {{(OPD_W-DIF_W){v[DIF_W-1]}}, v};
    endfunction

    function automatic logic signed [DIF_W-1:0] dif(input logic [CRD_W-1:0] u,
                                                     input logic [CRD_W-1:0] v);
        dif = $signed({u[CRD_W-1], u}) - $signed({v[CRD_W-1], v});
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.add && count_reg < CNT_W'(MAX_VERTICES))
        begin
            mem[count_reg[IDX_W-1:0]] <= in_data;
        end
        rd_reg <= mem[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.add)
        begin
            if (count_reg < CNT_W'(MAX_VERTICES))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.step)
            MS_AA0:  begin opa = sx(a_reg[0]); opb = sx(a_reg[0]); end
            MS_AA1:  begin opa = sx(a_reg[1]); opb = sx(a_reg[1]); end
            MS_AA2:  begin opa = sx(a_reg[2]); opb = sx(a_reg[2]); end
            MS_BB0:  begin opa = sx(b_reg[0]); opb = sx(b_reg[0]); end
            MS_BB1:  begin opa = sx(b_reg[1]); opb = sx(b_reg[1]); end
            MS_BB2:  begin opa = sx(b_reg[2]); opb = sx(b_reg[2]); end
            MS_AB0:  begin opa = sx(a_reg[0]); opb = sx(b_reg[0]); end
            MS_AB1:  begin opa = sx(a_reg[1]); opb = sx(b_reg[1]); end
            MS_AB2:  begin opa = sx(a_reg[2]); opb = sx(b_reg[2]); end
            MS_PA0:  begin opa = sx(p_reg[0]); opb = sx(a_reg[0]); end
            MS_PA1:  begin opa = sx(p_reg[1]); opb = sx(a_reg[1]); end
            MS_PA2:  begin opa = sx(p_reg[2]); opb = sx(a_reg[2]); end
            MS_PB0:  begin opa = sx(p_reg[0]); opb = sx(b_reg[0]); end
            MS_PB1:  begin opa = sx(p_reg[1]); opb = sx(b_reg[1]); end
            MS_PB2:  begin opa = sx(p_reg[2]); opb = sx(b_reg[2]); end
            MS_DEN0: begin opa = aa_reg; opb = bb_reg; end
            MS_DEN1: begin opa = ab_reg; opb = ab_reg; end
            MS_SN0:  begin opa = pa_reg; opb = bb_reg; end
            MS_SN1:  begin opa = pb_reg; opb = ab_reg; end
            MS_TN0:  begin opa = pb_reg; opb = aa_reg; end
            MS_TN1:  begin opa = pa_reg; opb = ab_reg; end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    psit_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .opa   (opa),
        .opb   (opb),
        .done  (mul_done),
        .prod  (prod)
    );

    assign prod_n = prod[OPD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.cap_q) q_reg  <= in_data;
        if (cmd.cap_a) va_reg <= rd_reg;
        if (cmd.cap_b) vb_reg <= rd_reg;
        if (cmd.cap_c) vc_reg <= rd_reg;
        if (cmd.diff)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k] <= dif(vb_reg[k*CRD_W +: CRD_W], va_reg[k*CRD_W +: CRD_W]);
                b_reg[k] <= dif(vc_reg[k*CRD_W +: CRD_W], va_reg[k*CRD_W +: CRD_W]);
                p_reg[k] <= dif(q_reg[k*CRD_W +: CRD_W], va_reg[k*CRD_W +: CRD_W]);
            end
        end
        if (cmd.mul_wb)
        begin
            unique case (cmd.step)
                MS_AA0:                    aa_reg  <= prod_n;
                MS_AA1, MS_AA2:            aa_reg  <= aa_reg + prod_n;
                MS_BB0:                    bb_reg  <= prod_n;
                MS_BB1, MS_BB2:            bb_reg  <= bb_reg + prod_n;
                MS_AB0:                    ab_reg  <= prod_n;
                MS_AB1, MS_AB2:            ab_reg  <= ab_reg + prod_n;
                MS_PA0:                    pa_reg  <= prod_n;
                MS_PA1, MS_PA2:            pa_reg  <= pa_reg + prod_n;
                MS_PB0:                    pb_reg  <= prod_n;
                MS_PB1, MS_PB2:            pb_reg  <= pb_reg + prod_n;
                MS_DEN0:                   den_reg <= prod;
                MS_DEN1:                   den_reg <= den_reg - prod;
                MS_SN0:                    sn_reg  <= prod;
                MS_SN1:                    sn_reg  <= sn_reg - prod;
                MS_TN0:                    tn_reg  <= prod;
                MS_TN1:                    tn_reg  <= tn_reg - prod;
                default:                   ;
            endcase
        end
        if (cmd.sum) sum_reg <= sn_reg + tn_reg;
    end

    assign slack = den_reg - sum_reg;

    always_comb
    begin
        st.count    = count_reg;
        st.ovf      = ovf_reg;
        st.mul_done = mul_done;
        st.hit      = !den_reg[WIDE_W-1] && (den_reg != '0) && !sn_reg[WIDE_W-1]
                      && !tn_reg[WIDE_W-1] && !slack[WIDE_W-1];
    end

endmodule

// File: src/psit_ctrl.sv
// Controller: stream handshakes, result register, triangle walk and multiply sequencing.
// Depends on psit_pkg.
module psit_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     in_kind,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_data,
    output psit_pkg::cmd_t cmd,
    input  psit_pkg::st_t  st
);
    import psit_pkg::*;

    state_t           state_reg, state_next;
    step_t            step_reg, step_next;
    logic [IDX_W-1:0] l_reg, l_next, m_reg, m_next, n_reg, n_next;
    logic             inside_reg, inside_next;
    logic             ov_reg, ov_next, oin_reg, oin_next, oovf_reg, oovf_next;
    logic             accept, more, n_ok, m_ok;

    assign in_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign n_ok     = CMP_W'(n_reg) + CMP_W'(1) < CMP_W'(st.count);
    assign m_ok     = CMP_W'(m_reg) + CMP_W'(2) < CMP_W'(st.count);
    assign more     = n_ok || m_ok || (CMP_W'(l_reg) + CMP_W'(3) < CMP_W'(st.count));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && in_kind == REQ_QUERY) state_next = ST_START;
            ST_START:  state_next = (st.count < CNT_W'(3)) ? ST_FINISH : ST_RD0;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_RD2;
            ST_RD2:    state_next = ST_RD3;
            ST_RD3:    state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MSTART;
            ST_MSTART: state_next = ST_MWAIT;
            ST_MWAIT:  if (st.mul_done) state_next = ST_MWB;
            ST_MWB:    state_next = (step_reg == MS_TN1) ? ST_SUM : ST_MSTART;
            ST_SUM:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = (st.hit || !more) ? ST_FINISH : ST_RD0;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.step    = step_reg;
        cmd.rd_addr = l_reg;
        step_next   = step_reg;
        l_next      = l_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        inside_next = inside_reg;
        ov_next     = ov_reg && !out_ready;
        oin_next    = oin_reg;
        oovf_next   = oovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.clear = accept && in_kind == REQ_CLEAR;
                cmd.add   = accept && in_kind == REQ_ADD;
                cmd.cap_q = accept && in_kind == REQ_QUERY;
            end
            ST_START:
            begin
                l_next      = IDX_W'(0);
                m_next      = IDX_W'(1);
                n_next      = IDX_W'(2);
                inside_next = 1'b0;
            end
            ST_RD0: cmd.rd_addr = l_reg;
            ST_RD1:
            begin
                cmd.rd_addr = m_reg;
                cmd.cap_a   = 1'b1;
            end
            ST_RD2:
            begin
                cmd.rd_addr = n_reg;
                cmd.cap_b   = 1'b1;
            end
            ST_RD3: cmd.cap_c = 1'b1;
            ST_DIFF:
            begin
                cmd.diff  = 1'b1;
                step_next = MS_AA0;
            end
            ST_MSTART: cmd.mul_start = 1'b1;
            ST_MWAIT:  ;
            ST_MWB:
            begin
                cmd.mul_wb = 1'b1;
                if (step_reg != MS_TN1) step_next = step_t'(step_reg + 1'b1);
            end
            ST_SUM: cmd.sum = 1'b1;
            ST_DECIDE:
            begin
                priority if (st.hit)
                begin
                    inside_next = 1'b1;
                end
                else if (n_ok)
                begin
                    n_next = n_reg + 1'b1;
                end
                else if (m_ok)
                begin
                    m_next = m_reg + 1'b1;
                    n_next = m_reg + IDX_W'(2);
                end
                else
                begin
                    l_next = l_reg + 1'b1;
                    m_next = l_reg + IDX_W'(2);
                    n_next = l_reg + IDX_W'(3);
                end
            end
            ST_FINISH:
            begin
                ov_next   = 1'b1;
                oin_next  = inside_reg;
                oovf_next = st.ovf;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= MS_AA0;
            l_reg      <= '0;
            m_reg      <= '0;
            n_reg      <= '0;
            inside_reg <= 1'b0;
            ov_reg     <= 1'b0;
            oin_reg    <= 1'b0;
            oovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            l_reg      <= l_next;
            m_reg      <= m_next;
            n_reg      <= n_next;
            inside_reg <= inside_next;
            ov_reg     <= ov_next;
            oin_reg    <= oin_next;
            oovf_reg   <= oovf_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = {6'b0, oovf_reg, oin_reg};

endmodule

// File: src/point_in_support_triangles_unit.sv
// Top level of the point-in-support-triangles unit.
// Depends on psit_pkg, psit_ctrl, psit_datapath (with psit_mul).
//
//  channel  | direction | payload
//  s_axis   | in        | tuser: req_type; tdata: coord_x, coord_y, coord_z
//  m_axis   | out       | tdata: inside_res, overflowed
//
// Clear and add are done in the idle state. A query walks the vertex triangles in index
// order and stops at the first hit; each triangle needs 21 products through one sequential
// multiplier built on 23x23-bit partial products. With fewer than three vertices a query
// answers without walking any triangle.
// Reset clears the vertex count, overflow flag and all control; the store needs no clearing.
// A waiting result holds in the output register; input stalls only while a query runs
// or while that register is full and not being taken.
module point_in_support_triangles_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [psit_pkg::VTX_W-1:0] s_axis_tdata,  // coord_x, coord_y, coord_z
    input  logic [1:0]                 s_axis_tuser,  // req_type
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata   // inside_res, overflowed, zero fill
);
    import psit_pkg::*;

    cmd_t cmd;
    st_t  st;

    psit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_kind   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .st        (st)
    );

    psit_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (s_axis_tdata),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

// File: src/psit_checker.sv
// Port-level checker for the point-in-support-triangles unit, bound to the top level.
// Depends on psit_pkg.
module psit_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [psit_pkg::VTX_W-1:0] s_axis_tdata,
    input logic [1:0]                 s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [7:0]                 m_axis_tdata
);
    import psit_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result transaction dropped or changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'b0)
        else $error("result padding not zero");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_QUERY |=> !s_axis_tready)
        else $error("input taken while a query runs");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_QUERY
        |=> s_axis_tready || (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled after a load or clear");

endmodule

bind point_in_support_triangles_unit psit_checker u_psit_checker (.*);

// File: bench/point_in_support_triangles_unit_tb.sv
// Testbench for point_in_support_triangles_unit: directed and random vertex loads and queries.
// Checks every result against a bit-exact triangle containment predictor; needs psit_pkg.
`timescale 1ns / 100ps

module point_in_support_triangles_unit_tb;
    import psit_pkg::*;

    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam int TIMEOUT_CYCLES = 6000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] c[3];
    } request_t;

    typedef struct {
        logic hit;
        logic ovf;
    } verdict_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [VTX_W-1:0]  s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;

    request_t           pending_reqs[$];
    verdict_t           expected_verdicts[$];
    request_t           cur_req;
    logic signed [31:0] model_vtx[MAX_VERTICES][3];
    int                 model_count;
    logic               model_ovf;
    int                 gap_left;
    int                 burst_left;
    int                 ready_hold;
    int                 mismatches;
    int                 cycles;
    logic signed [31:0] gen_vtx[MAX_VERTICES][3];
    int                 gen_count;

    point_in_support_triangles_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic triangle_holds(int ia, int ib, int ic, logic signed [31:0] q[3]);
        logic signed [191:0] ad[3];
        logic signed [191:0] bd[3];
        logic signed [191:0] pd[3];
        logic signed [191:0] aa, bb, ab, pa, pb, den, sn, tn, slack;
        for (int k = 0; k < 3; k++)
        begin
            ad[k] = model_vtx[ib][k];
            ad[k] = ad[k] - model_vtx[ia][k];
            bd[k] = model_vtx[ic][k];
            bd[k] = bd[k] - model_vtx[ia][k];
            pd[k] = q[k];
            pd[k] = pd[k] - model_vtx[ia][k];
        end
        aa = ad[0] * ad[0] + ad[1] * ad[1] + ad[2] * ad[2];
        bb = bd[0] * bd[0] + bd[1] * bd[1] + bd[2] * bd[2];
        ab = ad[0] * bd[0] + ad[1] * bd[1] + ad[2] * bd[2];
        pa = pd[0] * ad[0] + pd[1] * ad[1] + pd[2] * ad[2];
        pb = pd[0] * bd[0] + pd[1] * bd[1] + pd[2] * bd[2];
        den = aa * bb - ab * ab;
        if (den <= 0)
            return 1'b0;
        sn = pa * bb - pb * ab;
        tn = pb * aa - pa * ab;
        if (sn < 0 || tn < 0)
            return 1'b0;
        slack = den - (sn + tn);
        return slack >= 0;
    endfunction

    task automatic apply_request(request_t r);
        verdict_t v;
        case (r.kind)
            REQ_CLEAR:
            begin
                model_count = 0;
                model_ovf = 1'b0;
            end
            REQ_ADD:
            begin
                if (model_count < MAX_VERTICES)
                begin
                    for (int k = 0; k < 3; k++)
                        model_vtx[model_count][k] = r.c[k];
                    model_count++;
                end
                else
                    model_ovf = 1'b1;
            end
            REQ_QUERY:
            begin
                v.hit = 1'b0;
                v.ovf = model_ovf;
                for (int l = 0; l < model_count && !v.hit; l++)
                    for (int m = l + 1; m < model_count && !v.hit; m++)
                        for (int n = m + 1; n < model_count && !v.hit; n++)
                            v.hit = triangle_holds(l, m, n, r.c);
                expected_verdicts.push_back(v);
            end
            default: ;
        endcase
    endtask

    task automatic push_req(logic [1:0] kind, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        request_t r;
        r.kind = kind;
        r.c[0] = x;
        r.c[1] = y;
        r.c[2] = z;
        pending_reqs.push_back(r);
        if (kind == REQ_CLEAR)
            gen_count = 0;
        else if (kind == REQ_ADD && gen_count < MAX_VERTICES)
        begin
            gen_vtx[gen_count][0] = x;
            gen_vtx[gen_count][1] = y;
            gen_vtx[gen_count][2] = z;
            gen_count++;
        end
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
    endfunction

    // aim at a point of a stored triangle, with an optional random offset on each coordinate
    task automatic push_aimed_query();
        int a, b, c, u, w;
        longint p[3];
        a = $urandom_range(0, gen_count - 1);
        b = $urandom_range(0, gen_count - 1);
        c = $urandom_range(0, gen_count - 1);
        u = $urandom_range(0, 256);
        w = $urandom_range(0, 256 - u);
        for (int k = 0; k < 3; k++)
        begin
            p[k] = longint'(gen_vtx[a][k]) + ((longint'(gen_vtx[b][k]) -
                   longint'(gen_vtx[a][k])) * u + (longint'(gen_vtx[c][k]) -
                   longint'(gen_vtx[a][k])) * w) / 256;
            if ($urandom_range(0, 3) == 0)
                p[k] = p[k] + $signed($urandom_range(0, 2047)) - 1024;
        end
        push_req(REQ_QUERY, p[0][31:0], p[1][31:0], p[2][31:0]);
    endtask

    initial
    begin
        int nverts, nq;
        gen_count = 0;
        push_req(REQ_CLEAR, 0, 0, 0);
        push_req(REQ_QUERY, 0, 0, 0);
        push_req(REQ_ADD, 0, 0, 0);
        push_req(REQ_ADD, 32'sh000A_0000, 0, 0);
        push_req(REQ_QUERY, 32'sh0001_0000, 32'sh0001_0000, 0);
        push_req(REQ_ADD, 0, 32'sh000A_0000, 0);
        push_req(REQ_QUERY, 32'sh0003_0000, 32'sh0003_0000, 0);
        push_req(REQ_QUERY, 0, 0, 0);
        push_req(REQ_QUERY, 32'sh0005_0000, 32'sh0005_0000, 0);
        push_req(REQ_QUERY, 32'sh0008_0000, 32'sh0008_0000, 0);
        push_req(REQ_QUERY, 32'sh0002_0000, 32'sh0002_0000, 32'sh0100_0000);
        push_req(REQ_NOP, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_req(REQ_CLEAR, 0, 0, 0);
        push_req(REQ_ADD, 0, 0, 0);
        push_req(REQ_ADD, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        push_req(REQ_ADD, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000);
        push_req(REQ_QUERY, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        push_req(REQ_CLEAR, 0, 0, 0);
        push_req(REQ_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_req(REQ_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_req(REQ_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_req(REQ_QUERY, 0, 0, 0);
        push_req(REQ_QUERY, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_req(REQ_CLEAR, 0, 0, 0);
        for (int i = 0; i < MAX_VERTICES + 2; i++)
            push_req(REQ_ADD, rand_coord(), rand_coord(), rand_coord());
        push_aimed_query();
        while (pending_reqs.size() < 730)
        begin
            push_req(REQ_CLEAR, rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(0, 59) == 0)
                nverts = MAX_VERTICES + $urandom_range(0, 2);
            else if ($urandom_range(0, 7) == 0)
                nverts = $urandom_range(0, 2);
            else
                nverts = $urandom_range(3, 5);
            for (int i = 0; i < nverts; i++)
                push_req(REQ_ADD, rand_coord(), rand_coord(), rand_coord());
            nq = (nverts > MAX_VERTICES - 1) ? 1 : $urandom_range(1, 3);
            for (int i = 0; i < nq; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_req(REQ_NOP, $urandom, $urandom, $urandom);
                if (gen_count > 0 && $urandom_range(0, 3) != 0)
                    push_aimed_query();
                else
                    push_req(REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic load;
        logic next_valid;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= REQ_CLEAR;
            model_count = 0;
            model_ovf = 1'b0;
            gap_left = 0;
            burst_left = 1;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                apply_request(cur_req);
            load = !s_axis_tvalid || s_axis_tready;
            if (load)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
                s_axis_tvalid <= next_valid;
                if (next_valid)
                begin
                    s_axis_tdata <= {cur_req.c[2], cur_req.c[1], cur_req.c[0]};
                    s_axis_tuser <= cur_req.kind;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_hold = 0;
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result tdata=%h", m_axis_tdata);
                end
                else
                begin
                    v = expected_verdicts.pop_front();
                    if (m_axis_tdata !== {6'b0, v.ovf, v.hit})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: inside exp %b got %b, overflowed exp %b got %b",
                                     v.hit, m_axis_tdata[0], v.ovf, m_axis_tdata[1]);
                    end
                end
            end
            if (ready_hold > 0)
                ready_hold--;
            else
            begin
                if (m_axis_tready)
                begin
                    m_axis_tready <= ($urandom_range(0, 3) == 0);
                    ready_hold = $urandom_range(0, 8);
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    ready_hold = $urandom_range(1, 20);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > TIMEOUT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cycles = 0;
        @(posedge rst_n);
        @(posedge clk);
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: point_in_support_triangles_unit.f
src/psit_pkg.sv
src/psit_mul.sv
src/psit_datapath.sv
src/psit_ctrl.sv
src/point_in_support_triangles_unit.sv
src/psit_checker.sv
bench/point_in_support_triangles_unit_tb.sv
